// ----- hdl/dq_pkg.sv -----
package dq_pkg;

    localparam int DQ_CAPACITY = 16;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    typedef logic [CMD_W-1:0]        cmd_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [STATUS_W-1:0]     status_t;

    // command codes
    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_READ_FWD   = 3'd4;
    localparam cmd_t CMD_READ_BWD   = 3'd5;

    // status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // operation applied to the row of cells each cycle
    typedef logic [2:0] cell_op_t;
    localparam cell_op_t OP_HOLD       = 3'd0;
    localparam cell_op_t OP_PUSH_FRONT = 3'd1;
    localparam cell_op_t OP_PUSH_BACK  = 3'd2;
    localparam cell_op_t OP_POP_FRONT  = 3'd3;
    localparam cell_op_t OP_ROT_FWD    = 3'd4;
    localparam cell_op_t OP_ROT_BWD    = 3'd5;

    typedef struct packed {
        cell_op_t op;
        logic     active;   // cell holds a stored value
        logic     is_tail;  // cell holds the back value
        logic     is_next;  // first free cell behind the back
    } cell_ctl_t;

endpackage

// ----- hdl/dq_cmd_if.sv -----
interface dq_cmd_if;
    import dq_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  command;
    data_t value_in;

    modport source (output valid, output command, output value_in, input ready);
    modport sink   (input valid, input command, input value_in, output ready);
endinterface

// ----- hdl/dq_res_if.sv -----
interface dq_res_if;
    import dq_pkg::*;

    logic    valid;
    logic    ready;
    data_t   value_out;
    status_t status;
    logic    last;

    modport source (output valid, output value_out, output status, output last, input ready);
    modport sink   (input valid, input value_out, input status, input last, output ready);
endinterface

// ----- hdl/dq_cell.sv -----
module dq_cell (
    input  logic              clk,
    input  dq_pkg::cell_ctl_t ctl,
    input  dq_pkg::data_t     left,
    input  dq_pkg::data_t     right,
    input  dq_pkg::data_t     head,
    input  dq_pkg::data_t     value_in,
    output dq_pkg::data_t     value
);
    import dq_pkg::*;

    data_t value_reg;
    data_t value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.op)
            OP_PUSH_FRONT: value_next = left;
            OP_PUSH_BACK:
            begin
                if (ctl.is_next)
                begin
                    value_next = value_in;
                end
            end
            OP_POP_FRONT:  value_next = right;
            OP_ROT_FWD:
            begin
                if (ctl.is_tail)
                begin
                    value_next = head;
                end
                else if (ctl.active)
                begin
                    value_next = right;
                end
            end
            OP_ROT_BWD:
            begin
                if (ctl.active)
                begin
                    value_next = left;
                end
            end
            default:       value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
endmodule

// ----- hdl/dq_chain.sv -----
module dq_chain #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  dq_pkg::cell_op_t op,
    input  logic [CNT_W-1:0] count,
    input  dq_pkg::data_t    value_in,
    output dq_pkg::data_t    head,
    output dq_pkg::data_t    tail
);
    import dq_pkg::*;

    data_t     vals [CAPACITY];
    cell_ctl_t ctl  [CAPACITY];
    data_t     left_in [CAPACITY];
    data_t     right_in [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign ctl[i].op      = op;
        assign ctl[i].active  = CNT_W'(i) < count;
        assign ctl[i].is_tail = CNT_W'(i + 1) == count;
        assign ctl[i].is_next = CNT_W'(i) == count;

        if (i == 0)
        begin : g_first
            // front cell takes the new item, or the back value when rotating backward
            assign left_in[i] = (op == OP_ROT_BWD) ? tail : value_in;
        end
        else
        begin : g_mid
            assign left_in[i] = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in[i] = vals[i];
        end
        else
        begin : g_inner
            assign right_in[i] = vals[i+1];
        end

        dq_cell u_cell (
            .clk      (clk),
            .ctl      (ctl[i]),
            .left     (left_in[i]),
            .right    (right_in[i]),
            .head     (vals[0]),
            .value_in (value_in),
            .value    (vals[i])
        );
    end

    assign head = vals[0];

    // one-hot select of the back cell
    always_comb
    begin
        tail = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail = tail | (vals[i] & {DATA_W{ctl[i].is_tail}});
        end
    end
endmodule

// ----- hdl/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values. The values sit in a row of
// CAPACITY cells, front in cell 0, so no ring pointer is needed: a push at the front
// shifts the row back by one, a pop at the front shifts it forward, a push at the
// back writes the first free cell, a pop at the back just shrinks the count. Each
// push or pop gives one status item (ok, empty, or full when a push is refused). A
// read starts a walk and then gives one stored value per cycle while the result side
// keeps up, n items for n stored values with last on the final one, by rotating the
// occupied cells through the front (forward) or the back (backward) cell; after the
// read the row is back in its original order. A read of an empty queue gives one
// empty item. The next command is taken once a read has finished; push and pop
// commands can be taken every cycle while the result side keeps up. Commands 6 and 7
// are taken and ignored. Stored values power up undefined and carry no reset.
module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_cmd_if.sink   cmd,
    dq_res_if.source res
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // queue bookkeeping
    logic [CNT_W-1:0] count_reg, count_next;

    // read walk
    logic             busy_reg, busy_next;
    logic             bwd_reg, bwd_next;
    logic [CNT_W-1:0] remain_reg, remain_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    data_t   out_value_reg, out_value_next;
    status_t out_status_reg, out_status_next;
    logic    out_last_reg, out_last_next;

    cell_op_t op;
    data_t    head;
    data_t    tail;
    logic     out_free;
    logic     accept;
    logic     step;
    logic     is_full;
    logic     is_empty;

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = !busy_reg && out_free;
    assign accept    = cmd.valid && cmd.ready;
    assign step      = busy_reg && out_free;
    assign is_full   = count_reg == CNT_W'(CAPACITY);
    assign is_empty  = count_reg == '0;

    always_comb
    begin
        op              = OP_HOLD;
        count_next      = count_reg;
        busy_next       = busy_reg;
        bwd_next        = bwd_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (step)
        begin
            // emit one stored value and rotate the occupied cells
            op              = bwd_reg ? OP_ROT_BWD : OP_ROT_FWD;
            out_valid_next  = 1'b1;
            out_value_next  = bwd_reg ? tail : head;
            out_status_next = ST_OK;
            out_last_next   = remain_reg == CNT_W'(1);
            remain_next     = remain_reg - CNT_W'(1);
            if (remain_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (accept)
        begin
            out_value_next = '0;
            out_last_next  = 1'b1;
            unique case (cmd.command)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    out_valid_next = 1'b1;
                    if (is_full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        out_status_next = ST_OK;
                        op = (cmd.command == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    out_valid_next = 1'b1;
                    if (is_empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_status_next = ST_OK;
                        if (cmd.command == CMD_POP_FRONT)
                        begin
                            op = OP_POP_FRONT;
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_READ_FWD, CMD_READ_BWD:
                begin
                    if (is_empty)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        // start the walk; the values come out in the read steps that follow
                        busy_next   = 1'b1;
                        bwd_next    = cmd.command == CMD_READ_BWD;
                        remain_next = count_reg;
                    end
                end
                default:
                begin
                    // unused codes: no state change, no item
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            bwd_reg       <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            bwd_reg       <= bwd_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    dq_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .clk      (clk),
        .op       (op),
        .count    (count_reg),
        .value_in (cmd.value_in),
        .head     (head),
        .tail     (tail)
    );

    assign res.valid     = out_valid_reg;
    assign res.value_out = out_value_reg;
    assign res.status    = out_status_reg;
    assign res.last      = out_last_reg;
endmodule
